[rtl/cace_pkg.sv]
// shared constants and types of the costas array cost evaluator
package cace_pkg;

  localparam int MAX_SIZE_DEF = 32;
  localparam int PS_W         = 6;
  localparam int POS_W        = 5;
  localparam int VAL_W        = 6;
  localparam int MODE_W       = 3;
  localparam int COST_W       = 20;
  localparam int ERR_W        = 16;

  localparam logic [PS_W-1:0]   PS_RESET = 6'd8;
  localparam logic [COST_W-1:0] COST_MAX = 20'hFFFFF;
  localparam logic [ERR_W-1:0]  ERR_MAX  = 16'hFFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD     = 3'd0,
    MODE_COST     = 3'd1,
    MODE_COST_REC = 3'd2,
    MODE_TRIAL    = 3'd3,
    MODE_COMMIT   = 3'd4,
    MODE_READ     = 3'd5
  } mode_t;

endpackage

[rtl/cace_ram.sv]
// generic single write port ram with registered read
module cace_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cace_slot.sv]
// difference slot: (a + n - b) modulo twice the store depth
module cace_slot
  import cace_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic [VAL_W-1:0]                 a,
  input  logic [VAL_W-1:0]                 b,
  input  logic [$clog2(MAX_SIZE+1)-1:0]    n,
  output logic [$clog2(2*MAX_SIZE)-1:0]    slot
);

  localparam int DIFF  = 2 * MAX_SIZE;
  localparam int SW    = $clog2(DIFF);
  localparam int VMAX  = (1 << VAL_W) - 1;
  localparam int OFS   = DIFF * ((VMAX + DIFF - 1) / DIFF);
  localparam int XW    = 10;
  localparam int SH    = 18;
  localparam int RECIP = ((1 << SH) + DIFF - 1) / DIFF;

  logic [XW-1:0]    x;
  logic [XW+SH-1:0] prod;
  logic [XW-1:0]    q;
  logic [XW-1:0]    r;

  // offset is a multiple of the slot count so the sum never goes negative
  assign x    = XW'(a) + XW'(n) + XW'(OFS) - XW'(b);
  // reciprocal multiply, exact for x below 2**XW
  assign prod = (XW+SH)'(x) * (XW+SH)'(RECIP);
  assign q    = prod[XW+SH-1:SH];
  assign r    = x - q * XW'(DIFF);
  assign slot = r[SW-1:0];

endmodule

[rtl/costas_array_cost_evaluator.sv]
// top level: sequencer, stores and accumulator of the costas array cost evaluator
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  config   | config_write              | config_data (problem size)
//  input    | in_valid / in_stall       | mode, position_a, position_b, element_value
//  output   | out_valid / out_stall     | penalty_sum, variable_error
//
// load and unused modes go straight to done; read error goes through the error read state
// evaluation has an init state, a distance state per distance and pair, slot and count
// states per pair of every distance; in record modes each charge (up to 4 on a repeat)
// is an error memory read-modify-write; commit first swaps both positions in the stores
// synchronous reset idles the sequencer, sets the size register to its reset value and
// clears the valid bits of the count and error memories, so no clearing pass is needed
// in_stall stays high from a transfer until its result transfer completes
module costas_array_cost_evaluator
  import cace_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               config_write,
  input  logic [PS_W-1:0]    config_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  mode,
  input  logic [POS_W-1:0]   position_a,
  input  logic [POS_W-1:0]   position_b,
  input  logic [VAL_W-1:0]   element_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COST_W-1:0]  penalty_sum,
  output logic [ERR_W-1:0]   variable_error
);

  localparam int AW   = $clog2(MAX_SIZE);
  localparam int NW   = $clog2(MAX_SIZE + 1);
  localparam int DIFF = 2 * MAX_SIZE;
  localparam int SW   = $clog2(DIFF);
  localparam int PW   = 2 * NW;
  localparam int CW   = AW + 2;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_SWAP_RD = 14'b00000000000010,
    S_SWAP_WA = 14'b00000000000100,
    S_SWAP_WB = 14'b00000000001000,
    S_INIT    = 14'b00000000010000,
    S_DIST    = 14'b00000000100000,
    S_PAIR    = 14'b00000001000000,
    S_SLOT    = 14'b00000010000000,
    S_CNT     = 14'b00000100000000,
    S_CHG_RD  = 14'b00001000000000,
    S_CHG_WR  = 14'b00010000000000,
    S_ERR_RD  = 14'b00100000000000,
    S_ERR     = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_t;

  state_t state;

  // control and working registers
  logic [PS_W-1:0]   psize;
  logic [POS_W-1:0]  pa_q;
  logic [POS_W-1:0]  pb_q;
  logic              pa_ok;
  logic              swap_map;
  logic              rec;
  logic [NW-1:0]     n_q;
  logic [AW-1:0]     last_q;
  logic [AW-1:0]     d;
  logic [AW-1:0]     i;
  logic [PW-1:0]     dd;
  logic [PW-1:0]     nn;
  logic [PW-1:0]     pen;
  logic [COST_W-1:0] total;
  logic [ERR_W-1:0]  verr;
  logic [SW-1:0]     slot_q;
  logic [VAL_W-1:0]  va_q;
  logic [3:0]        pend;
  logic [AW-1:0]     chg_pos [4];
  logic [1:0]        chg_sel;
  logic [DIFF-1:0]     cnt_valid;
  logic [MAX_SIZE-1:0] err_valid;

  // memory ports
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [VAL_W-1:0]  st_wdata;
  logic [AW-1:0]     st0_raddr;
  logic [AW-1:0]     st1_raddr;
  logic [VAL_W-1:0]  st0_rd;
  logic [VAL_W-1:0]  st1_rd;
  logic [SW-1:0]     slot_c;
  logic              cnt_we;
  logic [CW-1:0]     cnt_wdata;
  logic [CW-1:0]     cnt_rd;
  logic              err_we;
  logic [AW-1:0]     err_raddr;
  logic [ERR_W-1:0]  err_wdata;
  logic [ERR_W-1:0]  err_rd;

  // combinational helpers
  logic              accept;
  logic [NW-1:0]     n_act;
  logic [NW-1:0]     half;
  logic [AW-1:0]     pa_i;
  logic [AW-1:0]     pb_i;
  logic [AW-1:0]     i_lo;
  logic [1:0]        old_cnt;
  logic [AW-1:0]     first_old;
  logic [COST_W:0]   tsum;
  logic [COST_W-1:0] total_add;
  logic [ERR_W:0]    esum;
  logic [ERR_W-1:0]  e_old;
  logic [1:0]        sel_c;
  logic [3:0]        pend_left;
  logic              last_pair;
  logic              last_dist;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign penalty_sum    = total;
  assign variable_error = verr;

  assign pa_i = AW'(pa_q);
  assign pb_i = AW'(pb_q);
  assign i_lo = i - d;

  function automatic logic [AW-1:0] remap(input logic [AW-1:0] p, input logic en,
                                          input logic [AW-1:0] x, input logic [AW-1:0] y);
    logic [AW-1:0] r;
    r = p;
    if (en && p == x) begin
      r = y;
    end else if (en && p == y) begin
      r = x;
    end
    return r;
  endfunction

  // problem size clamped to 2..MAX_SIZE
  always_comb begin
    if (psize < PS_W'(2)) begin
      n_act = NW'(2);
    end else if (int'(psize) > MAX_SIZE) begin
      n_act = NW'(MAX_SIZE);
    end else begin
      n_act = NW'(psize);
    end
    half = (n_act - NW'(1)) >> 1;
  end

  // two copies of the permutation store, one per pair member
  always_comb begin
    st_we    = 1'b0;
    st_waddr = pb_i;
    st_wdata = va_q;
    if (state == S_IDLE) begin
      st_we    = accept && (mode == MODE_LOAD) && (int'(position_a) < MAX_SIZE);
      st_waddr = AW'(position_a);
      st_wdata = element_value;
    end else if (state == S_SWAP_WA) begin
      st_we    = 1'b1;
      st_waddr = pa_i;
      st_wdata = st1_rd;
    end else if (state == S_SWAP_WB) begin
      st_we    = 1'b1;
    end
    if (state == S_SWAP_RD) begin
      st0_raddr = pa_i;
      st1_raddr = pb_i;
    end else begin
      st0_raddr = remap(i_lo, swap_map, pa_i, pb_i);
      st1_raddr = remap(i, swap_map, pa_i, pb_i);
    end
  end

  cace_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_store0 (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st0_raddr), .rdata(st0_rd)
  );

  cace_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIZE)) u_store1 (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st1_raddr), .rdata(st1_rd)
  );

  cace_slot #(.MAX_SIZE(MAX_SIZE)) u_slot (
    .a(st0_rd), .b(st1_rd), .n(n_q), .slot(slot_c)
  );

  // count memory word: first occurrence index over a saturating 0/1/2+ count
  always_comb begin
    old_cnt   = cnt_valid[slot_q] ? cnt_rd[1:0] : 2'd0;
    first_old = cnt_rd[CW-1:2];
    cnt_we    = (state == S_CNT);
    if (old_cnt == 2'd0) begin
      cnt_wdata = {i, 2'd1};
    end else begin
      cnt_wdata = {first_old, 2'd2};
    end
  end

  cace_ram #(.WIDTH(CW), .DEPTH(DIFF)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(slot_q), .wdata(cnt_wdata),
    .raddr(slot_c), .rdata(cnt_rd)
  );

  // pick the lowest pending charge
  always_comb begin
    sel_c = 2'd3;
    if (pend[0]) begin
      sel_c = 2'd0;
    end else if (pend[1]) begin
      sel_c = 2'd1;
    end else if (pend[2]) begin
      sel_c = 2'd2;
    end
    pend_left = pend & ~(4'b0001 << chg_sel);
  end

  always_comb begin
    err_raddr = (state == S_ERR_RD) ? pa_i : chg_pos[sel_c];
    e_old     = err_valid[chg_pos[chg_sel]] ? err_rd : '0;
    esum      = (ERR_W+1)'(e_old) + (ERR_W+1)'(pen);
    err_wdata = esum[ERR_W] ? ERR_MAX : esum[ERR_W-1:0];
    err_we    = (state == S_CHG_WR);
  end

  cace_ram #(.WIDTH(ERR_W), .DEPTH(MAX_SIZE)) u_errors (
    .clk(clk), .we(err_we), .waddr(chg_pos[chg_sel]), .wdata(err_wdata),
    .raddr(err_raddr), .rdata(err_rd)
  );

  // saturating cost accumulator
  always_comb begin
    tsum      = (COST_W+1)'(total) + (COST_W+1)'(pen);
    total_add = (tsum > (COST_W+1)'(COST_MAX)) ? COST_MAX : tsum[COST_W-1:0];
    last_pair = ((NW'(i) + NW'(1)) == n_q);
    last_dist = (d == last_q);
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      psize <= PS_RESET;
    end else if (config_write) begin
      psize <= config_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_valid <= '0;
      err_valid <= '0;
      pend      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pa_q     <= position_a;
            pb_q     <= position_b;
            pa_ok    <= (int'(position_a) < MAX_SIZE);
            total    <= '0;
            verr     <= '0;
            rec      <= 1'b0;
            swap_map <= 1'b0;
            case (mode)
              MODE_COST:     state <= S_INIT;
              MODE_COST_REC: begin
                rec   <= 1'b1;
                state <= S_INIT;
              end
              MODE_TRIAL: begin
                swap_map <= (int'(position_a) < MAX_SIZE) && (int'(position_b) < MAX_SIZE);
                state    <= S_INIT;
              end
              MODE_COMMIT: begin
                rec <= 1'b1;
                if ((int'(position_a) < MAX_SIZE) && (int'(position_b) < MAX_SIZE)) begin
                  state <= S_SWAP_RD;
                end else begin
                  state <= S_INIT;
                end
              end
              MODE_READ: state <= S_ERR_RD;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_SWAP_RD: state <= S_SWAP_WA;
        S_SWAP_WA: begin
          va_q  <= st0_rd;
          state <= S_SWAP_WB;
        end
        S_SWAP_WB: state <= S_INIT;
        S_INIT: begin
          n_q    <= n_act;
          nn     <= PW'(n_act) * PW'(n_act);
          last_q <= (half == '0) ? AW'(1) : AW'(half);
          d      <= AW'(1);
          dd     <= PW'(1);
          if (rec) begin
            for (int k = 0; k < MAX_SIZE; k++) begin
              if (k < int'(n_act)) begin
                err_valid[k] <= 1'b0;
              end
            end
          end
          state <= S_DIST;
        end
        S_DIST: begin
          pen       <= nn - dd;
          cnt_valid <= '0;
          i         <= d;
          state     <= S_PAIR;
        end
        S_PAIR: state <= S_SLOT;
        S_SLOT: begin
          slot_q <= slot_c;
          state  <= S_CNT;
        end
        S_CNT: begin
          cnt_valid[slot_q] <= 1'b1;
          if (old_cnt != 2'd0) begin
            total <= total_add;
          end
          chg_pos[0] <= first_old;
          chg_pos[1] <= first_old - d;
          chg_pos[2] <= i;
          chg_pos[3] <= i_lo;
          if (rec && old_cnt != 2'd0) begin
            pend  <= {2'b11, (old_cnt == 2'd1) && (first_old >= d), old_cnt == 2'd1};
            state <= S_CHG_RD;
          end else if (!last_pair) begin
            i     <= i + AW'(1);
            state <= S_PAIR;
          end else if (!last_dist) begin
            // (d+1)^2 = d^2 + 2d + 1
            d     <= d + AW'(1);
            dd    <= dd + (PW'(d) << 1) + PW'(1);
            state <= S_DIST;
          end else begin
            state <= S_DONE;
          end
        end
        S_CHG_RD: begin
          chg_sel <= sel_c;
          state   <= S_CHG_WR;
        end
        S_CHG_WR: begin
          err_valid[chg_pos[chg_sel]] <= 1'b1;
          pend <= pend_left;
          if (pend_left != '0) begin
            state <= S_CHG_RD;
          end else if (!last_pair) begin
            i     <= i + AW'(1);
            state <= S_PAIR;
          end else if (!last_dist) begin
            d     <= d + AW'(1);
            dd    <= dd + (PW'(d) << 1) + PW'(1);
            state <= S_DIST;
          end else begin
            state <= S_DONE;
          end
        end
        S_ERR_RD: state <= S_ERR;
        S_ERR: begin
          verr  <= (pa_ok && err_valid[pa_i]) ? err_rd : '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/cace_checker.sv]
// port level checker of the costas array cost evaluator and its bind
module cace_checker
  import cace_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [MODE_W-1:0] mode,
  input logic              out_valid,
  input logic              out_stall,
  input logic [COST_W-1:0] penalty_sum,
  input logic [ERR_W-1:0]  variable_error
);

  a_ready_after_reset: assert property (@(posedge clk) rst |=> !in_stall && !out_valid)
    else $error("block not ready after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("no busy after input transfer");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == MODE_LOAD) |=>
      out_valid && penalty_sum == '0 && variable_error == '0)
    else $error("load result wrong or late");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      out_valid && $stable(penalty_sum) && $stable(variable_error))
    else $error("stalled result changed");

endmodule

bind costas_array_cost_evaluator cace_checker u_cace_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
  .out_valid(out_valid), .out_stall(out_stall), .penalty_sum(penalty_sum),
  .variable_error(variable_error)
);

[tb/costas_array_cost_evaluator_tb.sv]
// self-checking testbench of the costas array cost evaluator
module costas_array_cost_evaluator_tb;
  import cace_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPOS = 32;
  localparam int SLOTS = 2 * NPOS;
  localparam int CYCLE_LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic config_write = 1'b0;
  logic [PS_W-1:0] config_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MODE_W-1:0] mode = '0;
  logic [POS_W-1:0] position_a = '0;
  logic [POS_W-1:0] position_b = '0;
  logic [VAL_W-1:0] element_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COST_W-1:0] penalty_sum;
  logic [ERR_W-1:0] variable_error;

  costas_array_cost_evaluator i_dut (
    .clk(clk), .rst(rst),
    .config_write(config_write), .config_data(config_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .position_a(position_a), .position_b(position_b),
    .element_value(element_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .penalty_sum(penalty_sum), .variable_error(variable_error)
  );

  always #1 clk = ~clk;

  // expected result of one transfer
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [ERR_W-1:0]  err;
  } score_t;

  score_t pending_scores[$];

  // shadow state of the block
  logic [PS_W-1:0]  size_reg;
  logic [VAL_W-1:0] perm[NPOS];
  logic [ERR_W-1:0] errs[NPOS];
  logic [4:0]       first_at[SLOTS];
  bit               written[NPOS];

  int unsigned failures = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit quiet_sender = 1'b0;   // no random gaps on the input side
  bit quiet_receiver = 1'b0; // no random stalls on the output side
  int hold_cycles = 0;       // long receiver hold-off, counted down by its own process
  int unsigned size_min_seen = 64, size_max_seen = 0;

  function automatic int unsigned clamp_size();
    int unsigned n;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > NPOS) n = NPOS;
    return n;
  endfunction

  function automatic void add_error(int unsigned pos, int unsigned pen);
    int unsigned v;
    if (pos >= NPOS) return;
    v = errs[pos] + pen;
    errs[pos] = (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // difference triangle scoring over the shadow permutation
  function automatic int unsigned score_perm(bit record);
    int unsigned n, last, pen, total, slot, cnt, fo;
    int unsigned counts[SLOTS];
    n = clamp_size();
    last = (n - 1) / 2;
    total = 0;
    if (last < 1) last = 1;
    if (record) for (int i = 0; i < n; i++) errs[i] = '0;
    for (int unsigned d = 1; d <= last; d++) begin
      pen = n * n - d * d;
      foreach (counts[k]) counts[k] = 0;
      for (int unsigned i = d; i < n; i++) begin
        slot = (perm[i-d] + n + 64 * SLOTS - perm[i]) % SLOTS;
        cnt = counts[slot];
        if (cnt < 255) cnt++;
        counts[slot] = cnt;
        if (record) begin
          if (cnt == 1) begin
            first_at[slot] = i[4:0];
          end else begin
            if (cnt == 2) begin
              fo = first_at[slot];
              add_error(fo, pen);
              if (fo >= d) add_error(fo - d, pen);
            end
            add_error(i, pen);
            add_error(i - d, pen);
          end
        end
        if (cnt > 1) begin
          total += pen;
          if (total > 1048575) total = 1048575;
        end
      end
    end
    return total;
  endfunction

  function automatic void swap_perm(int unsigned a, int unsigned b);
    logic [VAL_W-1:0] t;
    t = perm[a];
    perm[a] = perm[b];
    perm[b] = t;
  endfunction

  function automatic score_t predict(logic [MODE_W-1:0] m, logic [POS_W-1:0] pa,
                                     logic [POS_W-1:0] pb, logic [VAL_W-1:0] v);
    score_t r;
    r = '0;
    case (m)
      MODE_LOAD: begin
        perm[pa] = v;
        written[pa] = 1'b1;
      end
      MODE_COST:     r.cost = score_perm(1'b0);
      MODE_COST_REC: r.cost = score_perm(1'b1);
      MODE_TRIAL: begin
        swap_perm(pa, pb);
        r.cost = score_perm(1'b0);
        swap_perm(pa, pb);
      end
      MODE_COMMIT: begin
        swap_perm(pa, pb);
        r.cost = score_perm(1'b1);
      end
      MODE_READ: r.err = errs[pa];
      default: ;
    endcase
    return r;
  endfunction

  // one input transfer; valid stays high across back-to-back items unless a random gap is drawn
  task automatic send_item(logic [MODE_W-1:0] m, logic [POS_W-1:0] pa,
                           logic [POS_W-1:0] pb, logic [VAL_W-1:0] v);
    if (!quiet_sender) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    mode <= m;
    position_a <= pa;
    position_b <= pb;
    element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_scores.push_back(predict(m, pa, pb, v));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_size(int unsigned n);
    wait_drained();
    config_write <= 1'b1;
    config_data <= n[PS_W-1:0];
    @(negedge clk);
    config_write <= 1'b0;
    size_reg = n[PS_W-1:0];
    if (clamp_size() < size_min_seen) size_min_seen = clamp_size();
    if (clamp_size() > size_max_seen) size_max_seen = clamp_size();
  endtask

  // load a random permutation of 1..n into positions 0..n-1
  task automatic load_perm(int unsigned n);
    int unsigned vals[NPOS];
    int unsigned j, t;
    for (int i = 0; i < n; i++) vals[i] = i + 1;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = vals[i]; vals[i] = vals[j]; vals[j] = t;
    end
    for (int i = 0; i < n; i++) send_item(MODE_LOAD, POS_W'(i), '0, VAL_W'(vals[i]));
  endtask

  // the store must be written in 0..n-1 before evaluation; fill the rest too
  task automatic fill_unwritten();
    for (int i = 0; i < NPOS; i++)
      if (!written[i]) send_item(MODE_LOAD, POS_W'(i), '0, VAL_W'($urandom_range(1, 32)));
  endtask

  // directed: extremes of fields, every mode, unused modes, sizes out of range
  task automatic test_directed();
    set_size(8);
    send_item(MODE_LOAD, 0, 0, 6'd63); // stray value, may alias
    send_item(MODE_LOAD, 31, 0, 6'd0);
    fill_unwritten();
    load_perm(8);
    send_item(MODE_COST, 0, 0, 0);
    send_item(MODE_COST_REC, 0, 0, 0);
    send_item(MODE_READ, 0, 0, 0);
    send_item(MODE_READ, 31, 0, 0);
    send_item(MODE_TRIAL, 0, 7, 0);
    send_item(MODE_TRIAL, 31, 31, 0);
    send_item(MODE_COMMIT, 1, 6, 0);
    send_item(MODE_READ, 6, 0, 0);
    send_item(3'd6, 5'h1F, 5'h1F, 6'h3F);
    send_item(3'd7, 0, 0, 0);
    // identical values everywhere give the worst repeats
    for (int i = 0; i < 8; i++) send_item(MODE_LOAD, POS_W'(i), '0, 6'd1);
    send_item(MODE_COST_REC, 0, 0, 0);
    send_item(MODE_READ, 3, 0, 0);
    set_size(0);  // clamps to two
    send_item(MODE_COST_REC, 0, 0, 0);
    set_size(63); // clamps to the store size
    send_item(MODE_COST_REC, 0, 0, 0);
    send_item(MODE_READ, 20, 0, 0);
  endtask

  // random: mostly swap searches over valid permutations, some noise
  task automatic test_random(int unsigned count);
    int unsigned n, r;
    while (count > 0) begin
      r = $urandom_range(99);
      if (r < 8) n = 32;
      else if (r < 15) n = 2;
      else n = $urandom_range(3, 14);
      set_size(n);
      load_perm(n);
      send_item(MODE_COST_REC, 0, 0, 0);
      for (int k = 0; k < 30 && count > 0; k++, count--) begin
        r = $urandom_range(99);
        if (r < 30)
          send_item(MODE_TRIAL, POS_W'($urandom_range(n - 1)), POS_W'($urandom_range(n - 1)),
                    VAL_W'($urandom));
        else if (r < 45)
          send_item(MODE_COMMIT, POS_W'($urandom_range(n - 1)), POS_W'($urandom_range(n - 1)),
                    VAL_W'($urandom));
        else if (r < 65)
          send_item(MODE_READ, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
        else if (r < 72)
          send_item(MODE_COST, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
        else if (r < 78)
          send_item(MODE_COST_REC, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
        else if (r < 86)
          send_item(MODE_TRIAL, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
        else if (r < 93)
          send_item(MODE_LOAD, POS_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
        else
          send_item(MODE_W'($urandom_range(6, 7)), POS_W'($urandom), POS_W'($urandom),
                    VAL_W'($urandom));
      end
    end
  endtask

  // receiver holds off while the sender keeps offering; then a pause until drained
  task automatic test_backpressure();
    set_size(6);
    load_perm(6);
    hold_cycles = 300;
    for (int k = 0; k < 12; k++)
      send_item(MODE_TRIAL, POS_W'($urandom_range(5)), POS_W'($urandom_range(5)), '0);
    wait_drained();
    send_item(MODE_COST, 0, 0, 0);
  endtask

  // no idling on either side for a long stretch
  task automatic test_no_idle();
    quiet_sender = 1'b1;
    quiet_receiver = 1'b1;
    test_random(120);
    wait_drained();
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  // output side: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_receiver && ($urandom_range(99) < 21);
    end
  end

  // checker: compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    score_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected result cost %0d error %0d", $time, penalty_sum,
                 variable_error);
        failures++;
      end else begin
        want = pending_scores.pop_front();
        if (penalty_sum !== want.cost) begin
          $display("%0t: penalty_sum expected %0d actual %0d", $time, want.cost, penalty_sum);
          failures++;
        end
        if (variable_error !== want.err) begin
          $display("%0t: variable_error expected %0d actual %0d", $time, want.err,
                   variable_error);
          failures++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("[costas_array_cost_evaluator] ERROR");
      $finish;
    end
  end

  initial begin
    size_reg = PS_RESET;
    foreach (perm[i]) begin
      perm[i] = '0;
      errs[i] = '0;
      written[i] = 1'b0;
    end
    foreach (first_at[i]) first_at[i] = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_no_idle();
    test_random(670);
    wait_drained();
    repeat (600) @(negedge clk);
    if (pending_scores.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_scores.size());
      failures++;
    end
    $display("covered %0d transfers in, %0d results, sizes %0d to %0d", items_sent,
             results_seen, size_min_seen, size_max_seen);
    $display("all modes, unused modes, swaps out of range, long output hold-off");
    if (failures == 0) begin
      $display("[costas_array_cost_evaluator] OK");
    end else begin
      $display("[costas_array_cost_evaluator] ERROR");
    end
    $finish;
  end

endmodule
